// ----- hdl/chi_pkg.sv -----
package chi_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
    localparam int ATAN_W     = 22;
    localparam int STEPS      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 17;
    localparam int HEAD_W   = 15;
    localparam int PRESHIFT = 8;
    localparam int CW       = 28;
    localparam int ZW       = 25;
    localparam int HW       = 27;

    localparam int DEG_Q16     = 65536;
    localparam int Q16_90      = 90 * DEG_Q16;
    localparam int Q16_180     = 180 * DEG_Q16;
    localparam int Q16_270     = 270 * DEG_Q16;
    localparam int Q16_360     = 360 * DEG_Q16;
    localparam int ROUND_ADD   = 1 << (15 - ANGLE_FRAC_BITS);
    localparam int ROUND_SHIFT = 16 - ANGLE_FRAC_BITS;

    typedef enum logic [1:0] {
        OP_ACQUIRE   = 2'd0,
        OP_CALIBRATE = 2'd1,
        OP_RUN       = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORR,
        ST_INIT,
        ST_ITER,
        ST_ANGLE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              corr;
        logic              init;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              angle;
        logic              finish;
    } dp_cmd_t;

    typedef struct packed {
        logic run;
        logic y_zero;
        logic out_free;
    } dp_stat_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/chi_ctrl.sv -----
module chi_ctrl
    import chi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_CORR;
            end
            ST_CORR:
            begin
                state_next = stat.run ? ST_INIT : ST_FINISH;
            end
            ST_INIT:
            begin
                state_next = stat.y_zero ? ST_ANGLE : ST_ITER;
            end
            ST_ITER:
            begin
                if (step_reg == STEP_W'(STEPS - 1))
                    state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (state_reg == ST_INIT)
            step_next = '0;
        else if (state_reg == ST_ITER && step_reg != STEP_W'(STEPS - 1))
            step_next = step_reg + 1'b1;
    end

    always_comb
    begin
        sample_ready = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && sample_valid;
        cmd.corr     = (state_reg == ST_CORR);
        cmd.init     = (state_reg == ST_INIT);
        cmd.iter     = (state_reg == ST_ITER);
        cmd.step     = step_reg;
        cmd.angle    = (state_reg == ST_ANGLE);
        cmd.finish   = (state_reg == ST_FINISH) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- hdl/chi_datapath.sv -----
module chi_datapath
    import chi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [1:0]               opcode,
    input  logic signed [SAMPLE_W-1:0] axis_x,
    input  logic signed [SAMPLE_W-1:0] axis_y,
    input  logic signed [SAMPLE_W-1:0] axis_z,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     heading_valid,
    output logic [HEAD_W-1:0]        heading,
    output logic signed [CORR_W-1:0] corrected_x,
    output logic signed [CORR_W-1:0] corrected_y,
    output logic signed [CORR_W-1:0] corrected_z
);

    op_t                         op_reg, op_next;
    logic signed [SAMPLE_W-1:0]  samp_reg [3];
    logic signed [SAMPLE_W-1:0]  samp_next [3];
    logic signed [SAMPLE_W-1:0]  max_reg [3];
    logic signed [SAMPLE_W-1:0]  max_next [3];
    logic signed [SAMPLE_W-1:0]  min_reg [3];
    logic signed [SAMPLE_W-1:0]  min_next [3];
    logic signed [SAMPLE_W-1:0]  off_reg [3];
    logic signed [SAMPLE_W-1:0]  off_next [3];
    logic signed [CORR_W-1:0]    corr_reg [3];
    logic signed [CORR_W-1:0]    corr_next [3];
    logic signed [CW-1:0]        x_reg, x_next;
    logic signed [CW-1:0]        y_reg, y_next;
    logic signed [ZW-1:0]        z_reg, z_next;
    logic [HW-1:0]               h_reg, h_next;
    logic                        rvalid_reg, rvalid_next;
    logic                        hvalid_reg, hvalid_next;
    logic [HEAD_W-1:0]           head_reg, head_next;
    logic signed [CORR_W-1:0]    cout_reg [3];
    logic signed [CORR_W-1:0]    cout_next [3];

    logic signed [CORR_W-1:0]    mid_sum [3];
    logic signed [CORR_W-1:0]    den, num;
    logic signed [CW-1:0]        xs, ys;
    logic signed [ZW-1:0]        atan_val;
    logic signed [HW-1:0]        h_raw;
    logic [HW-1:0]               h_round;

    assign stat.run      = (op_reg == OP_RUN);
    assign stat.y_zero   = (corr_reg[1] == '0);
    assign stat.out_free = !rvalid_reg || result_ready;

    always_comb
    begin
        op_next      = op_reg;
        samp_next[0] = samp_reg[0];
        samp_next[1] = samp_reg[1];
        samp_next[2] = samp_reg[2];
        if (cmd.load)
        begin
            op_next      = op_t'(opcode);
            samp_next[0] = axis_x;
            samp_next[1] = axis_y;
            samp_next[2] = axis_z;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            max_next[k]  = max_reg[k];
            min_next[k]  = min_reg[k];
            off_next[k]  = off_reg[k];
            corr_next[k] = corr_reg[k];
            mid_sum[k]   = CORR_W'(max_reg[k]) + CORR_W'(min_reg[k]);
            if (cmd.corr)
            begin
                corr_next[k] = CORR_W'(samp_reg[k]) - CORR_W'(off_reg[k]);
                if (op_reg == OP_ACQUIRE)
                begin
                    if (max_reg[k] == '0 && min_reg[k] == '0)
                    begin
                        max_next[k] = samp_reg[k];
                        min_next[k] = samp_reg[k];
                    end
                    else
                    begin
                        if (samp_reg[k] > max_reg[k])
                            max_next[k] = samp_reg[k];
                        if (samp_reg[k] < min_reg[k])
                            min_next[k] = samp_reg[k];
                    end
                end
                else if (op_reg == OP_CALIBRATE)
                begin
                    // round the midpoint toward zero
                    off_next[k] = SAMPLE_W'((mid_sum[k] + CORR_W'(mid_sum[k][CORR_W-1])) >>> 1);
                end
            end
        end
    end

    always_comb
    begin
        den      = corr_reg[1][CORR_W-1] ? -corr_reg[1] : corr_reg[1];
        num      = corr_reg[1][CORR_W-1] ? -corr_reg[0] : corr_reg[0];
        xs       = x_reg >>> cmd.step;
        ys       = y_reg >>> cmd.step;
        atan_val = signed'(ZW'(atan_q16(ATAN_IDX_W'(cmd.step))));
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        if (cmd.init)
        begin
            x_next = CW'(den) <<< PRESHIFT;
            y_next = CW'(num) <<< PRESHIFT;
            z_next = '0;
        end
        else if (cmd.iter)
        begin
            if (!y_reg[CW-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_val;
            end
        end
    end

    always_comb
    begin
        if (corr_reg[1][CORR_W-1])
            h_raw = HW'(Q16_270) - HW'(z_reg);
        else
            h_raw = HW'(Q16_90) - HW'(z_reg);
        h_next = h_reg;
        if (cmd.angle)
        begin
            if (corr_reg[1] == '0)
                h_next = (corr_reg[0] > 0) ? '0 : HW'(Q16_180);
            else if (h_raw < 0)
                h_next = '0;
            else if (h_raw > HW'(Q16_360))
                h_next = HW'(Q16_360);
            else
                h_next = h_raw;
        end
    end

    always_comb
    begin
        h_round      = (h_reg + HW'(ROUND_ADD)) >> ROUND_SHIFT;
        rvalid_next  = rvalid_reg;
        hvalid_next  = hvalid_reg;
        head_next    = head_reg;
        cout_next[0] = cout_reg[0];
        cout_next[1] = cout_reg[1];
        cout_next[2] = cout_reg[2];
        if (cmd.finish)
        begin
            rvalid_next = 1'b1;
            if (op_reg == OP_RUN)
            begin
                hvalid_next  = 1'b1;
                head_next    = h_round[HEAD_W-1:0];
                cout_next[0] = corr_reg[0];
                cout_next[1] = corr_reg[1];
                cout_next[2] = corr_reg[2];
            end
            else
            begin
                hvalid_next  = 1'b0;
                head_next    = '0;
                cout_next[0] = '0;
                cout_next[1] = '0;
                cout_next[2] = '0;
            end
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                max_reg[k] <= '0;
                min_reg[k] <= '0;
                off_reg[k] <= '0;
            end
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            for (int k = 0; k < 3; k++)
            begin
                max_reg[k] <= max_next[k];
                min_reg[k] <= min_next[k];
                off_reg[k] <= off_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        h_reg      <= h_next;
        hvalid_reg <= hvalid_next;
        head_reg   <= head_next;
        for (int k = 0; k < 3; k++)
        begin
            samp_reg[k] <= samp_next[k];
            corr_reg[k] <= corr_next[k];
            cout_reg[k] <= cout_next[k];
        end
    end

    assign result_valid  = rvalid_reg;
    assign heading_valid = hvalid_reg;
    assign heading       = head_reg;
    assign corrected_x   = cout_reg[0];
    assign corrected_y   = cout_reg[1];
    assign corrected_z   = cout_reg[2];

endmodule

// ----- hdl/compass_hard_iron_heading.sv -----
// Heading beat: offset subtract, CORDIC setup, one cycle per CORDIC iteration (16, none when
// corrected y is zero), angle clamp, result load into the output register.
// Acquire, calibrate and unused opcodes go from offset subtract straight to result load.
// One beat in work at a time; the next is taken the cycle after the result loads,
// and the result load waits while the output register still holds an unread result.
// rst_n is asynchronous, active low; clears min, max, offsets, result_valid and the controller state.
module compass_hard_iron_heading
    import chi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic [1:0]                 opcode,
    input  logic signed [SAMPLE_W-1:0] axis_x,
    input  logic signed [SAMPLE_W-1:0] axis_y,
    input  logic signed [SAMPLE_W-1:0] axis_z,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic                       heading_valid,
    output logic [HEAD_W-1:0]          heading,
    output logic signed [CORR_W-1:0]   corrected_x,
    output logic signed [CORR_W-1:0]   corrected_y,
    output logic signed [CORR_W-1:0]   corrected_z
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    chi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    chi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .axis_x        (axis_x),
        .axis_y        (axis_y),
        .axis_z        (axis_z),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .heading_valid (heading_valid),
        .heading       (heading),
        .corrected_x   (corrected_x),
        .corrected_y   (corrected_y),
        .corrected_z   (corrected_z)
    );

endmodule

// ----- sim/compass_hard_iron_heading_test.sv -----
module compass_hard_iron_heading_test;
    import chi_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint PRE_SCALE = 256;
    localparam longint ARC_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } sample_t;

    typedef struct packed {
        logic               hv;
        logic [14:0]        hd;
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic signed [16:0] cz;
    } fix_t;

    typedef struct {
        int mx [3];
        int mn [3];
        int off [3];
    } cal_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic [1:0]                 opcode = 2'd0;
    logic signed [SAMPLE_W-1:0] axis_x = '0;
    logic signed [SAMPLE_W-1:0] axis_y = '0;
    logic signed [SAMPLE_W-1:0] axis_z = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       heading_valid;
    logic [HEAD_W-1:0]          heading;
    logic signed [CORR_W-1:0]   corrected_x;
    logic signed [CORR_W-1:0]   corrected_y;
    logic signed [CORR_W-1:0]   corrected_z;

    sample_t feed_q [$];
    fix_t    fix_q [$];
    cal_t    dut_cal;
    cal_t    gen_cal;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      queued_items = 0;
    int      cycles = 0;
    int      errors = 0;
    int      mismatches = 0;
    int      checked = 0;
    int      n_acq = 0;
    int      n_cal = 0;
    int      n_run = 0;
    int      n_zero_y = 0;
    int      n_unused = 0;

    compass_hard_iron_heading uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .opcode        (opcode),
        .axis_x        (axis_x),
        .axis_y        (axis_y),
        .axis_z        (axis_z),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .heading_valid (heading_valid),
        .heading       (heading),
        .corrected_x   (corrected_x),
        .corrected_y   (corrected_y),
        .corrected_z   (corrected_z)
    );

    always #5 clk = ~clk;

    function automatic longint vector_angle(input longint den, input longint num);
        longint px;
        longint py;
        longint pz;
        longint sx;
        longint sy;
        int     n;
        px = den * PRE_SCALE;
        py = num * PRE_SCALE;
        pz = 0;
        n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int i = 0; i < n; i++)
        begin
            sx = px >>> i;
            sy = py >>> i;
            if (py >= 0)
            begin
                px = px + sy;
                py = py - sx;
                pz = pz + ARC_Q16[i];
            end
            else
            begin
                px = px - sy;
                py = py + sx;
                pz = pz - ARC_Q16[i];
            end
        end
        return pz;
    endfunction

    function automatic fix_t compass_step(inout cal_t st, input sample_t s);
        int     v [3];
        longint c [3];
        longint h;
        longint hd;
        fix_t   r;
        v[0] = s.x;
        v[1] = s.y;
        v[2] = s.z;
        r = '0;
        case (s.op)
            OP_ACQUIRE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (st.mx[k] == 0 && st.mn[k] == 0)
                    begin
                        st.mx[k] = v[k];
                        st.mn[k] = v[k];
                    end
                    else
                    begin
                        if (v[k] > st.mx[k])
                            st.mx[k] = v[k];
                        if (v[k] < st.mn[k])
                            st.mn[k] = v[k];
                    end
                end
            end
            OP_CALIBRATE:
            begin
                for (int k = 0; k < 3; k++)
                    st.off[k] = (st.mx[k] + st.mn[k]) / 2;
            end
            OP_RUN:
            begin
                for (int k = 0; k < 3; k++)
                    c[k] = longint'(v[k]) - longint'(st.off[k]);
                if (c[1] == 0)
                    h = (c[0] > 0) ? 0 : 180 * 65536;
                else if (c[1] < 0)
                    h = 270 * 65536 - vector_angle(-c[1], -c[0]);
                else
                    h = 90 * 65536 - vector_angle(c[1], c[0]);
                if (h < 0)
                    h = 0;
                if (h > 360 * 65536)
                    h = 360 * 65536;
                hd = (h + (64'sd1 <<< (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
                r.hv = 1'b1;
                r.hd = hd[14:0];
                r.cx = c[0][16:0];
                r.cy = c[1][16:0];
                r.cz = c[2][16:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int clip16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int rnd16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int jitter(input int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    task automatic add_item(input logic [1:0] op, input int x, input int y, input int z);
        sample_t s;
        fix_t    unused_fix;
        s.op = op;
        s.x = x[15:0];
        s.y = y[15:0];
        s.z = z[15:0];
        unused_fix = compass_step(gen_cal, s);
        feed_q.push_back(s);
        if (op != OP_UNUSED)
            queued_items++;
    endtask

    // acquire around a random center, latch offsets, then take headings; sometimes add one to four random-opcode items
    task automatic add_session();
        int ctr [3];
        int rad;
        int n;
        int sel;
        int x;
        int y;
        int z;
        bit wide;
        wide = ($urandom_range(7) == 0);
        for (int k = 0; k < 3; k++)
            ctr[k] = wide ? rnd16() : int'($urandom_range(40000)) - 20000;
        rad = $urandom_range(16000, 50);
        n = $urandom_range(12, 3);
        repeat (n)
            add_item(OP_ACQUIRE, clip16(ctr[0] + jitter(rad)), clip16(ctr[1] + jitter(rad)),
                     clip16(ctr[2] + jitter(rad)));
        add_item(OP_CALIBRATE, rnd16(), rnd16(), rnd16());
        n = $urandom_range(20, 6);
        repeat (n)
        begin
            sel = $urandom_range(9);
            x = clip16(ctr[0] + jitter(rad));
            y = clip16(ctr[1] + jitter(rad));
            z = clip16(ctr[2] + jitter(rad));
            if (sel == 0)
            begin
                y = gen_cal.off[1];
                if ($urandom_range(1))
                    x = clip16(gen_cal.off[0] + int'($urandom_range(2)) - 1);
            end
            else if (sel == 1)
                x = gen_cal.off[0];
            else if (sel == 2)
            begin
                x = rnd16();
                y = rnd16();
                z = rnd16();
            end
            add_item(OP_RUN, x, y, z);
        end
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(4, 1))
                add_item(2'($urandom_range(3)), rnd16(), rnd16(), rnd16());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (feed_q.size() != 0 || sample_valid || fix_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        sample_t s;
        fix_t    f;
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && sample_ready)
            begin
                s.op = opcode;
                s.x = axis_x;
                s.y = axis_y;
                s.z = axis_z;
                f = compass_step(dut_cal, s);
                fix_q.push_back(f);
                case (s.op)
                    OP_ACQUIRE:   n_acq++;
                    OP_CALIBRATE: n_cal++;
                    OP_RUN:
                    begin
                        n_run++;
                        if (f.cy == 0)
                            n_zero_y++;
                    end
                    default:      n_unused++;
                endcase
            end
            if (!sample_valid || sample_ready)
            begin
                if (feed_q.size() != 0 && $urandom_range(99) >= send_gap)
                begin
                    s = feed_q.pop_front();
                    sample_valid <= 1'b1;
                    opcode <= s.op;
                    axis_x <= s.x;
                    axis_y <= s.y;
                    axis_z <= s.z;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        fix_t got;
        fix_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got = {heading_valid, heading, corrected_x, corrected_y, corrected_z};
                if (fix_q.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected result beat: hv=%0d hd=%0d x=%0d y=%0d z=%0d",
                                 got.hv, got.hd, got.cx, got.cy, got.cz);
                    mismatches++;
                end
                else
                begin
                    want = fix_q.pop_front();
                    checked++;
                    if (got.hv !== want.hv || got.hd !== want.hd || got.cx !== want.cx
                        || got.cy !== want.cy || got.cz !== want.cz)
                    begin
                        errors++;
                        if (mismatches < 10)
                        begin
                            $display("result beat %0d: exp hv=%0d hd=%0d x=%0d y=%0d z=%0d",
                                     checked, want.hv, want.hd, want.cx, want.cy, want.cz);
                            $display("    got hv=%0d hd=%0d x=%0d y=%0d z=%0d",
                                     got.hv, got.hd, got.cx, got.cy, got.cz);
                        end
                        mismatches++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_gap);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, fix_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < 3; k++)
        begin
            dut_cal.mx[k] = 0;
            dut_cal.mn[k] = 0;
            dut_cal.off[k] = 0;
            gen_cal.mx[k] = 0;
            gen_cal.mn[k] = 0;
            gen_cal.off[k] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_gap = 34;
        recv_gap = 79;
        add_item(OP_ACQUIRE, 0, 0, 0);
        add_item(OP_ACQUIRE, 100, -200, 300);
        add_item(OP_ACQUIRE, 32767, -32768, 0);
        add_item(OP_ACQUIRE, -32768, 32767, -1);
        add_item(OP_RUN, 5, 0, 0);
        add_item(OP_RUN, 0, 0, 0);
        add_item(OP_RUN, -7, 0, 32767);
        add_item(OP_RUN, 0, 100, -32768);
        add_item(OP_RUN, 0, -100, 1);
        add_item(OP_RUN, 32767, -32768, -1);
        add_item(OP_RUN, -32768, 1, 0);
        add_item(OP_RUN, -32768, -1, 0);
        add_item(OP_RUN, 1, -32768, 0);
        add_item(OP_RUN, 32767, 32767, 32767);
        add_item(OP_UNUSED, -1, -1, -1);
        add_item(OP_RUN, -21555, 10922, -1);
        add_item(OP_CALIBRATE, 0, 0, 0);
        add_item(OP_RUN, 32767, -32768, -32768);
        add_item(OP_RUN, -32768, 32767, 32767);
        add_item(OP_RUN, 3, 0, 149);
        add_item(OP_RUN, -3, 0, 150);
        add_item(OP_ACQUIRE, 32767, 32767, 32767);
        add_item(OP_CALIBRATE, -32768, -32768, -32768);
        add_item(OP_RUN, -32768, -32768, -32768);
        while (queued_items < 470)
            add_session();
        wait_drained();

        send_gap = 79;
        recv_gap = 34;
        while (queued_items < 940)
            add_session();
        wait_drained();

        send_gap = 0;
        recv_gap = 0;
        while (queued_items < 1400)
            add_session();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        errors = errors + fix_q.size();
        $display("covered %0d acquire, %0d calibrate, %0d heading (%0d with zero y), %0d unused",
                 n_acq, n_cal, n_run, n_zero_y, n_unused);
        $display("checked %0d result beats in %0d cycles, %0d mismatches",
                 checked, cycles, mismatches);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
